// ===== rtl/adsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared widths, reset values, register indexes, segment kinds and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // Field widths.
  localparam int unsigned VOICE_W = 3;
  localparam int unsigned POS_W   = 24;
  localparam int unsigned LEN_W   = 18;
  localparam int unsigned LVL_W   = 16;
  localparam int unsigned MULT_W  = 16;
  localparam int unsigned PROD_W  = LEN_W + MULT_W;

  // Stream widths: tdata holds voice then note_pos, padded to whole bytes.
  localparam int unsigned IN_BITS     = VOICE_W + POS_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((LVL_W + 7) / 8) * 8;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = LEN_W;

  // Level scale, Q1.15.
  localparam logic [LVL_W-1:0] FULL_SCALE = LVL_W'(32768);

  // Divider: the quotient never exceeds full scale, so 16 steps suffice.
  localparam int unsigned DIV_STEPS = LVL_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Reset values of the configuration registers.
  localparam logic [LEN_W-1:0]  ATTACK_LEN_RST    = LEN_W'(480);
  localparam logic [LEN_W-1:0]  DECAY_LEN_RST     = LEN_W'(4800);
  localparam logic [LVL_W-1:0]  SUSTAIN_LEVEL_RST = LVL_W'(16384);
  localparam logic [MULT_W-1:0] RELEASE_MULT_RST  = MULT_W'(65000);

  localparam int unsigned DEFAULT_VOICES = 8;

  // Register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ATTACK_LEN    = 2'd0,
    REG_DECAY_LEN     = 2'd1,
    REG_SUSTAIN_LEVEL = 2'd2,
    REG_RELEASE_MULT  = 2'd3
  } cfg_reg_e;

  // Which rule produces the level of the current item.
  typedef enum logic [2:0] {
    KIND_DROP,
    KIND_RELEASE,
    KIND_FULL,
    KIND_ATTACK,
    KIND_DECAY,
    KIND_SUSTAIN
  } kind_e;

  // Controller to datapath.
  typedef struct packed {
    logic mul;
    logic div_init;
    logic div_step;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    kind_e kind;
    logic  out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/adsr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADSR envelope datapath
// Configuration registers, per-voice level store, shared multiplier,
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module adsr_datapath #(
  parameter int unsigned VOICES = adsr_pkg::DEFAULT_VOICES
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration writes.
  input  wire logic                               cfg_we_i,
  input  wire logic [adsr_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [adsr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input item, captured on load.
  input  wire logic                               load_i,
  input  wire logic [adsr_pkg::VOICE_W-1:0]       voice_i,
  input  wire logic                               gate_i,
  input  wire logic [adsr_pkg::POS_W-1:0]         note_pos_i,
  // Control.
  input  wire adsr_pkg::cmd_t                     cmd_i,
  output adsr_pkg::status_t                       status_o,
  // Result.
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [adsr_pkg::LVL_W-1:0]              level_o
);

  // Only voices the field can name are stored.
  localparam int unsigned MAX_DEPTH = 2 ** adsr_pkg::VOICE_W;
  localparam int unsigned DEPTH     = (VOICES < MAX_DEPTH) ? VOICES : MAX_DEPTH;
  localparam int unsigned SW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int unsigned LEN_W  = adsr_pkg::LEN_W;
  localparam int unsigned LVL_W  = adsr_pkg::LVL_W;
  localparam int unsigned MULT_W = adsr_pkg::MULT_W;
  localparam int unsigned PROD_W = adsr_pkg::PROD_W;
  localparam int unsigned POS_W  = adsr_pkg::POS_W;

  logic [LEN_W-1:0]  attack_len_q;
  logic [LEN_W-1:0]  decay_len_q;
  logic [LVL_W-1:0]  sustain_level_q;
  logic [MULT_W-1:0] release_mult_q;

  logic [LVL_W-1:0]  store_q [DEPTH];

  logic [adsr_pkg::VOICE_W-1:0] voice_q;
  logic                         gate_q;
  logic [POS_W-1:0]             pos_q;
  logic [LVL_W-1:0]             prev_q;
  logic [PROD_W-1:0]            prod_q;
  logic [LEN_W-1:0]             rem_q;
  logic [LVL_W-1:0]             num_q;
  logic [LVL_W-1:0]             quo_q;
  logic                         out_valid_q;
  logic [LVL_W-1:0]             level_q;

  logic                         in_range_in;
  logic                         in_range;
  logic [LVL_W-1:0]             sus_sat;
  logic [LEN_W:0]               att_dec_sum;
  logic [LEN_W-1:0]             pos_low;
  logic [LEN_W-1:0]             decay_off;
  adsr_pkg::kind_e              kind;
  logic [LEN_W-1:0]             mul_a;
  logic [MULT_W-1:0]            mul_b;
  logic [LEN_W-1:0]             divisor;
  logic [LEN_W:0]               rem_shift;
  logic [LEN_W:0]               rem_diff;
  logic [LVL_W-1:0]             level_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_len_q    <= adsr_pkg::ATTACK_LEN_RST;
      decay_len_q     <= adsr_pkg::DECAY_LEN_RST;
      sustain_level_q <= adsr_pkg::SUSTAIN_LEVEL_RST;
      release_mult_q  <= adsr_pkg::RELEASE_MULT_RST;
    end else if (cfg_we_i) begin
      case (adsr_pkg::cfg_reg_e'(cfg_addr_i))
        adsr_pkg::REG_ATTACK_LEN:    attack_len_q    <= cfg_data_i;
        adsr_pkg::REG_DECAY_LEN:     decay_len_q     <= cfg_data_i;
        adsr_pkg::REG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data_i[LVL_W-1:0];
        adsr_pkg::REG_RELEASE_MULT:  release_mult_q  <= cfg_data_i[MULT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_range_in = (32'(voice_i) < DEPTH);
  assign in_range    = (32'(voice_q) < DEPTH);

  // Capture the item and the voice's previous level.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      voice_q <= voice_i;
      gate_q  <= gate_i;
      pos_q   <= note_pos_i;
      prev_q  <= in_range_in ? store_q[voice_i[SW-1:0]] : '0;
    end
  end

  // Segment classification from the captured item and the registers.
  assign sus_sat     = (sustain_level_q > adsr_pkg::FULL_SCALE) ?
                       adsr_pkg::FULL_SCALE : sustain_level_q;
  assign att_dec_sum = {1'b0, attack_len_q} + {1'b0, decay_len_q};
  assign pos_low     = pos_q[LEN_W-1:0];
  assign decay_off   = pos_low - attack_len_q;

  always_comb begin
    if (!in_range) begin
      kind = adsr_pkg::KIND_DROP;
    end else if (!gate_q) begin
      kind = adsr_pkg::KIND_RELEASE;
    end else if (pos_q <= POS_W'(attack_len_q)) begin
      kind = (attack_len_q == '0) ? adsr_pkg::KIND_FULL : adsr_pkg::KIND_ATTACK;
    end else if ((decay_len_q != '0) && (pos_q <= POS_W'(att_dec_sum))) begin
      kind = adsr_pkg::KIND_DECAY;
    end else begin
      kind = adsr_pkg::KIND_SUSTAIN;
    end
  end

  // Multiplier operands and divisor per segment.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    divisor = decay_len_q;
    case (kind)
      adsr_pkg::KIND_RELEASE: begin
        mul_a = LEN_W'(prev_q);
        mul_b = release_mult_q;
      end
      adsr_pkg::KIND_ATTACK: begin
        mul_a   = pos_low;
        mul_b   = MULT_W'(adsr_pkg::FULL_SCALE);
        divisor = attack_len_q;
      end
      adsr_pkg::KIND_DECAY: begin
        mul_a = decay_off;
        mul_b = MULT_W'(adsr_pkg::FULL_SCALE - sus_sat);
      end
      default: ;
    endcase
  end

  // One restoring divider step: shift in a numerator bit, subtract if it fits.
  assign rem_shift = {rem_q, num_q[LVL_W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd_i.div_init) begin
      rem_q <= prod_q[PROD_W-1:LVL_W];
      num_q <= prod_q[LVL_W-1:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[LVL_W-2:0], 1'b0};
      if (!rem_diff[LEN_W]) begin
        rem_q <= rem_diff[LEN_W-1:0];
        quo_q <= {quo_q[LVL_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift[LEN_W-1:0];
        quo_q <= {quo_q[LVL_W-2:0], 1'b0};
      end
    end
  end

  // Final level per segment.
  always_comb begin
    case (kind)
      adsr_pkg::KIND_RELEASE: level_d = prod_q[LVL_W+MULT_W-1:MULT_W];
      adsr_pkg::KIND_FULL:    level_d = adsr_pkg::FULL_SCALE;
      adsr_pkg::KIND_ATTACK:  level_d = (prev_q > quo_q) ? prev_q : quo_q;
      adsr_pkg::KIND_DECAY:   level_d = adsr_pkg::FULL_SCALE - quo_q;
      adsr_pkg::KIND_SUSTAIN: level_d = sus_sat;
      default:                level_d = '0;
    endcase
  end

  // Level store, cleared at reset, written back when the item finishes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (cmd_i.finish && in_range) begin
      store_q[voice_q[SW-1:0]] <= level_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      level_q <= level_d;
    end
  end

  assign status_o.kind     = kind;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign level_o           = level_q;

endmodule

`default_nettype wire

// ===== rtl/adsr_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADSR envelope controller
// Sequences one item through multiply, division for attack and decay items, and write-back.
// ----------------------------------------------------------------------------
module adsr_controller (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire adsr_pkg::status_t status_i,
  output adsr_pkg::cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                       state_q;
  logic [adsr_pkg::CNT_W-1:0]   cnt_q;
  logic                         needs_div;

  assign needs_div = (status_i.kind == adsr_pkg::KIND_ATTACK) ||
                     (status_i.kind == adsr_pkg::KIND_DECAY);

  // State and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= needs_div ? ST_DINIT : ST_FIN;
        end
        ST_DINIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == adsr_pkg::CNT_W'(adsr_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!status_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Commands decoded from the state.
  assign in_ready_o      = (state_q == ST_IDLE);
  assign cmd_o.mul       = (state_q == ST_MUL);
  assign cmd_o.div_init  = (state_q == ST_DINIT);
  assign cmd_o.div_step  = (state_q == ST_DIV);
  assign cmd_o.finish    = (state_q == ST_FIN) && !status_i.out_busy;

endmodule

`default_nettype wire

// ===== rtl/adsr_envelope_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Attack and decay items go through the multiplier and the 16-step restoring divider;
// release, sustain, drop and zero-length attack items skip the divider. One item is
// in flight at a time: no new item is taken until the current result has entered
// the output register, which waits while the result channel stalls.
// Reset is asynchronous and active low; it clears all voice levels to zero and
// loads the register defaults, with no clearing pass.
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Multi-voice envelope level per sample: linear attack and decay, sustain
// hold and multiplicative release, with one stored Q1.15 level per voice.
// ----------------------------------------------------------------------------
module adsr_envelope_generator #(
  parameter int unsigned VOICES = adsr_pkg::DEFAULT_VOICES
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input stream.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [adsr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // voice, note_pos, zeros
  input  wire logic                                s_axis_tuser,  // gate
  // Output stream.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [adsr_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // level
  // Configuration writes.
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [adsr_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  wire logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned VW = adsr_pkg::VOICE_W;
  localparam int unsigned PW = adsr_pkg::POS_W;

  adsr_pkg::cmd_t                cmd;
  adsr_pkg::status_t             status;
  logic                          in_ready;
  logic                          in_fire;
  logic [adsr_pkg::LVL_W-1:0]    level;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = in_ready;
  assign in_fire       = s_axis_tvalid && in_ready;
  assign m_axis_tdata  = adsr_pkg::OUT_TDATA_W'(level);

  adsr_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adsr_datapath #(
    .VOICES (VOICES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .load_i      (in_fire),
    .voice_i     (s_axis_tdata[VW-1:0]),
    .gate_i      (s_axis_tuser),
    .note_pos_i  (s_axis_tdata[VW+PW-1:VW]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .level_o     (level)
  );

  // The block takes no new item in the cycle after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  // A result is only produced when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote an untaken output");

  // Controller issues at most one command per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.mul, cmd.div_init, cmd.div_step, cmd.finish}))
    else $error("overlapping controller commands");

  // Levels never exceed full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (level <= adsr_pkg::FULL_SCALE))
    else $error("level above full scale");

endmodule

`default_nettype wire
